FILE: design/svdw_pkg.sv
// Shared widths, register codes and beat types for the sphere pair force block.
package svdw_pkg;

   localparam int NUM_TYPES = 2;
   localparam int POS_W     = 32;
   localparam int RAD_W     = 24;
   localparam int OUT_W     = 48;
   localparam int CFG_W     = 64;
   localparam int NUM_REGS  = 3;
   localparam int ADDR_W    = 5;
   localparam int AD_W      = 27;
   localparam int RSQ_W     = 56;
   localparam int ROOT_W    = 28;
   localparam int RSUM_W    = 25;
   localparam int HAM_W     = 24;
   localparam int GAP_W     = 20;
   localparam int CUT_W     = 20;
   localparam int E_W       = 46;
   localparam int FRAC_W    = 16;
   localparam int FMAG_W    = 62;
   localparam int DEN_W     = 31;

   localparam logic [1:0] REG_AA = 2'd0;
   localparam logic [1:0] REG_AB = 2'd1;
   localparam logic [1:0] REG_BB = 2'd2;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_i_x;
      logic signed [POS_W-1:0] pos_i_y;
      logic signed [POS_W-1:0] pos_i_z;
      logic signed [POS_W-1:0] pos_j_x;
      logic signed [POS_W-1:0] pos_j_y;
      logic signed [POS_W-1:0] pos_j_z;
      logic [RAD_W-1:0]        radius_i;
      logic [RAD_W-1:0]        radius_j;
      logic                    type_i;
      logic                    type_j;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] force_x;
      logic signed [OUT_W-1:0] force_y;
      logic signed [OUT_W-1:0] force_z;
      logic signed [OUT_W-1:0] pair_energy;
      logic                    in_range;
   } rsp_type;

   typedef struct packed {
      logic                       inr;
      logic [2:0]                 dpos;
      logic [2:0][AD_W-1:0]       ad;
      logic [RSQ_W-1:0]           rsq;
      logic [RSUM_W-1:0]          radsum;
      logic [RAD_W-1:0]           ri;
      logic [RAD_W-1:0]           rj;
      logic [HAM_W-1:0]           ham;
      logic [GAP_W-1:0]           gmin;
   } front_type;

endpackage

FILE: design/svdw_front.sv
// Front pipeline: separation, coefficient select, squared distance and range test.
module svdw_front import svdw_pkg::*; (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  req_type                         in_data,
   input  logic [NUM_REGS-1:0][CFG_W-1:0]  coeff,
   output logic                            out_valid,
   output front_type                       out_data
);

   localparam int Stages = 5;

   typedef struct packed {
      logic [2:0][POS_W:0]        d;
      logic                       far;
      logic [2:0]                 dpos;
      logic [2:0][AD_W-1:0]       ad;
      logic [2:0][2*AD_W-1:0]     sq;
      logic [RSUM_W-1:0]          radsum;
      logic [RAD_W-1:0]           ri;
      logic [RAD_W-1:0]           rj;
      logic [HAM_W-1:0]           ham;
      logic [GAP_W-1:0]           gmin;
      logic [CUT_W-1:0]           cut;
      logic [RSUM_W:0]            hb;
      logic [2*RSUM_W-1:0]        lo;
      logic [2*RSUM_W+1:0]        hi;
      logic [RSQ_W-1:0]           rsq;
      logic                       inr;
   } fstage_type;

   fstage_type         st_ff [Stages];
   fstage_type         st_in [Stages];
   logic [Stages-1:0]  vld_ff;

   always_comb begin
      logic [2:0][POS_W-1:0] pi;
      logic [2:0][POS_W-1:0] pj;
      logic                  ti;
      logic                  tj;
      logic [1:0]            sel;
      logic [CFG_W-1:0]      cw;
      pi = {in_data.pos_i_x, in_data.pos_i_y, in_data.pos_i_z};
      pj = {in_data.pos_j_x, in_data.pos_j_y, in_data.pos_j_z};
      ti = ({31'b0, in_data.type_i} >= NUM_TYPES) ? 1'(NUM_TYPES - 1) : in_data.type_i;
      tj = ({31'b0, in_data.type_j} >= NUM_TYPES) ? 1'(NUM_TYPES - 1) : in_data.type_j;
      priority if (!ti && !tj) begin
         sel = REG_AA;
      end else if (ti && tj) begin
         sel = REG_BB;
      end else begin
         sel = REG_AB;
      end
      cw = coeff[sel];
      st_in[0] = '0;
      for (int k = 0; k < 3; k++) begin
         st_in[0].d[k] = {pi[k][POS_W-1], pi[k]} - {pj[k][POS_W-1], pj[k]};
      end
      st_in[0].ri     = in_data.radius_i;
      st_in[0].rj     = in_data.radius_j;
      st_in[0].radsum = RSUM_W'(in_data.radius_i) + RSUM_W'(in_data.radius_j);
      st_in[0].ham    = cw[HAM_W-1:0];
      st_in[0].gmin   = cw[HAM_W+GAP_W-1:HAM_W];
      st_in[0].cut    = cw[CFG_W-1:HAM_W+GAP_W];
   end

   always_comb begin
      logic [POS_W:0] ab;
      st_in[1] = st_ff[0];
      st_in[1].far = 1'b0;
      for (int k = 0; k < 3; k++) begin
         ab = st_ff[0].d[k][POS_W] ? (~st_ff[0].d[k] + 1'b1) : st_ff[0].d[k];
         st_in[1].far     = st_in[1].far | (|ab[POS_W:AD_W]);
         st_in[1].ad[k]   = ab[AD_W-1:0];
         st_in[1].dpos[k] = !st_ff[0].d[k][POS_W] && (st_ff[0].d[k] != '0);
      end
      st_in[1].hb = {1'b0, st_ff[0].radsum} + (RSUM_W+1)'(st_ff[0].cut);
   end

   always_comb begin
      st_in[2] = st_ff[1];
      for (int k = 0; k < 3; k++) begin
         st_in[2].sq[k] = st_ff[1].ad[k] * st_ff[1].ad[k];
      end
      st_in[2].lo = st_ff[1].radsum * st_ff[1].radsum;
      st_in[2].hi = st_ff[1].hb * st_ff[1].hb;
   end

   always_comb begin
      st_in[3] = st_ff[2];
      st_in[3].rsq = RSQ_W'(st_ff[2].sq[0]) + RSQ_W'(st_ff[2].sq[1])
                   + RSQ_W'(st_ff[2].sq[2]);
   end

   always_comb begin
      st_in[4] = st_ff[3];
      st_in[4].inr = !st_ff[3].far && (st_ff[3].rsq > RSQ_W'(st_ff[3].lo))
                   && (st_ff[3].rsq <= RSQ_W'(st_ff[3].hi));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < Stages; s++) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[Stages-2:0], in_valid};
      end
   end

   assign out_valid       = vld_ff[Stages-1];
   assign out_data.inr    = st_ff[Stages-1].inr;
   assign out_data.dpos   = st_ff[Stages-1].dpos;
   assign out_data.ad     = st_ff[Stages-1].ad;
   assign out_data.rsq    = st_ff[Stages-1].rsq;
   assign out_data.radsum = st_ff[Stages-1].radsum;
   assign out_data.ri     = st_ff[Stages-1].ri;
   assign out_data.rj     = st_ff[Stages-1].rj;
   assign out_data.ham    = st_ff[Stages-1].ham;
   assign out_data.gmin   = st_ff[Stages-1].gmin;

endmodule

FILE: design/svdw_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module svdw_isqrt import svdw_pkg::*; #(
   parameter int NW = RSQ_W,
   parameter int SW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [NW-1:0]   in_value,
   input  logic [SW-1:0]   in_side,
   output logic            out_valid,
   output logic [NW/2-1:0] out_root,
   output logic [SW-1:0]   out_side
);

   localparam int Steps = NW / 2;

   logic [NW-1:0]    v_ff    [Steps];
   logic [NW-1:0]    res_ff  [Steps];
   logic [SW-1:0]    side_ff [Steps];
   logic [Steps-1:0] vld_ff;

   genvar k;
   generate
      for (k = 0; k < Steps; k++) begin : g_step
         localparam logic [NW-1:0] StepBit = {{(NW-1){1'b0}}, 1'b1} << (NW - 2 - 2*k);
         logic [NW-1:0] v_src;
         logic [NW-1:0] res_src;
         logic [SW-1:0] side_src;
         logic [NW:0]   trial;
         logic [NW-1:0] v_in;
         logic [NW-1:0] res_in;
         if (k == 0) begin : g_first
            assign v_src    = in_value;
            assign res_src  = '0;
            assign side_src = in_side;
         end else begin : g_next
            assign v_src    = v_ff[k-1];
            assign res_src  = res_ff[k-1];
            assign side_src = side_ff[k-1];
         end
         assign trial = {1'b0, res_src} + {1'b0, StepBit};
         always_comb begin
            if ({1'b0, v_src} >= trial) begin
               v_in   = v_src - trial[NW-1:0];
               res_in = (res_src >> 1) + StepBit;
            end else begin
               v_in   = v_src;
               res_in = res_src >> 1;
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               v_ff[k]    <= v_in;
               res_ff[k]  <= res_in;
               side_ff[k] <= side_src;
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[Steps-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[Steps-1];
   assign out_root  = res_ff[Steps-1][NW/2-1:0];
   assign out_side  = side_ff[Steps-1];

endmodule

FILE: design/svdw_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module svdw_div import svdw_pkg::*; #(
   parameter int NW = FMAG_W,
   parameter int DW = ROOT_W,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [NW-1:0] out_quot,
   output logic [SW-1:0] out_side
);

   logic [DW-1:0] rem_ff  [NW];
   logic [NW-1:0] nq_ff   [NW];
   logic [DW-1:0] dv_ff   [NW];
   logic [SW-1:0] side_ff [NW];
   logic [NW-1:0] vld_ff;

   genvar k;
   generate
      for (k = 0; k < NW; k++) begin : g_step
         logic [DW-1:0] rem_src;
         logic [NW-1:0] nq_src;
         logic [DW-1:0] dv_src;
         logic [SW-1:0] side_src;
         logic [DW:0]   rem2;
         logic [DW:0]   diff;
         logic          ge;
         if (k == 0) begin : g_first
            assign rem_src  = '0;
            assign nq_src   = in_num;
            assign dv_src   = in_den;
            assign side_src = in_side;
         end else begin : g_next
            assign rem_src  = rem_ff[k-1];
            assign nq_src   = nq_ff[k-1];
            assign dv_src   = dv_ff[k-1];
            assign side_src = side_ff[k-1];
         end
         assign rem2 = {rem_src, nq_src[NW-1]};
         assign diff = rem2 - {1'b0, dv_src};
         assign ge   = rem2 >= {1'b0, dv_src};
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k]  <= ge ? diff[DW-1:0] : rem2[DW-1:0];
               nq_ff[k]   <= {nq_src[NW-2:0], ge};
               dv_ff[k]   <= dv_src;
               side_ff[k] <= side_src;
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NW-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[NW-1];
   assign out_quot  = nq_ff[NW-1];
   assign out_side  = side_ff[NW-1];

endmodule

FILE: design/svdw_muldiv.sv
// Pipelined floor(a*b/c) for a not above c, one bit of b per stage.
module svdw_muldiv import svdw_pkg::*; #(
   parameter int BW = FMAG_W,
   parameter int CW = ROOT_W,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [CW-1:0] in_a,
   input  logic [BW-1:0] in_b,
   input  logic [CW-1:0] in_c,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [BW-1:0] out_quot,
   output logic [SW-1:0] out_side
);

   logic [CW-1:0] rem_ff  [BW];
   logic [BW-1:0] b_ff    [BW];
   logic [BW-1:0] q_ff    [BW];
   logic [CW-1:0] a_ff    [BW];
   logic [CW-1:0] c_ff    [BW];
   logic [SW-1:0] side_ff [BW];
   logic [BW-1:0] vld_ff;

   genvar k;
   generate
      for (k = 0; k < BW; k++) begin : g_step
         logic [CW-1:0] rem_src;
         logic [BW-1:0] b_src;
         logic [BW-1:0] q_src;
         logic [CW-1:0] a_src;
         logic [CW-1:0] c_src;
         logic [SW-1:0] side_src;
         logic [CW+1:0] t;
         logic [CW+1:0] t1;
         logic [CW+1:0] t2;
         logic [CW-1:0] rem_in;
         logic [1:0]    digit;
         if (k == 0) begin : g_first
            assign rem_src  = '0;
            assign b_src    = in_b;
            assign q_src    = '0;
            assign a_src    = in_a;
            assign c_src    = in_c;
            assign side_src = in_side;
         end else begin : g_next
            assign rem_src  = rem_ff[k-1];
            assign b_src    = b_ff[k-1];
            assign q_src    = q_ff[k-1];
            assign a_src    = a_ff[k-1];
            assign c_src    = c_ff[k-1];
            assign side_src = side_ff[k-1];
         end
         assign t  = {1'b0, rem_src, 1'b0} + (CW+2)'(b_src[BW-1] ? a_src : '0);
         assign t1 = t - (CW+2)'(c_src);
         assign t2 = t - {1'b0, c_src, 1'b0};
         always_comb begin
            priority if (t >= {1'b0, c_src, 1'b0}) begin
               rem_in = t2[CW-1:0];
               digit  = 2'd2;
            end else if (t >= (CW+2)'(c_src)) begin
               rem_in = t1[CW-1:0];
               digit  = 2'd1;
            end else begin
               rem_in = t[CW-1:0];
               digit  = 2'd0;
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k]  <= rem_in;
               b_ff[k]    <= {b_src[BW-2:0], 1'b0};
               q_ff[k]    <= {q_src[BW-2:0], 1'b0} + BW'(digit);
               a_ff[k]    <= a_src;
               c_ff[k]    <= c_src;
               side_ff[k] <= side_src;
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[BW-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[BW-1];
   assign out_quot  = q_ff[BW-1];
   assign out_side  = side_ff[BW-1];

endmodule

FILE: design/sphere_vdw_pair_force.sv
// Sphere pair van der Waals force: each accepted req beat yields its rsp beat.
// Throughput: one pair per cycle; the whole pipeline advances together and holds
// only while the two-entry result buffer is full.
// The chained bit-per-stage units have these stage counts: root 28, reduced radius 24,
// energy divide 48, force magnitude divide 62, per-axis scaling 62.
// Synchronous reset clears the coefficient registers to zero and empties the pipeline.
module sphere_vdw_pair_force import svdw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [CFG_W-1:0]  csr_pwdata,
   output logic [CFG_W-1:0]  csr_prdata,
   output logic              csr_pready
);

   typedef struct packed {
      logic                 inr;
      logic [2:0]           dpos;
      logic [2:0][AD_W-1:0] ad;
      logic [RSUM_W-1:0]    radsum;
      logic [RAD_W-1:0]     ri;
      logic [RAD_W-1:0]     rj;
      logic [HAM_W-1:0]     ham;
      logic [GAP_W-1:0]     gmin;
   } sq_side_type;

   typedef struct packed {
      logic                 inr;
      logic [2:0]           dpos;
      logic [2:0][AD_W-1:0] ad;
      logic [HAM_W-1:0]     ham;
      logic [ROOT_W-1:0]    h;
      logic [ROOT_W-1:0]    r;
   } md_side_type;

   typedef struct packed {
      logic                 inr;
      logic [2:0]           dpos;
      logic [2:0][AD_W-1:0] ad;
      logic [ROOT_W-1:0]    h;
      logic [ROOT_W-1:0]    r;
   } ed_side_type;

   typedef struct packed {
      logic                 inr;
      logic [2:0]           dpos;
      logic [2:0][AD_W-1:0] ad;
      logic [ROOT_W-1:0]    r;
      logic [E_W-1:0]       e;
   } fd_side_type;

   typedef struct packed {
      logic           inr;
      logic [E_W-1:0] e;
      logic           dpos;
   } lane_side_type;

   function automatic logic [OUT_W-1:0] sat_force(input logic pos, input logic [FMAG_W-1:0] m);
      logic [OUT_W-1:0] f;
      logic             big;
      big = |m[FMAG_W-1:OUT_W-1];
      if (pos) begin
         f = big ? {1'b1, {(OUT_W-1){1'b0}}} : (~m[OUT_W-1:0] + 1'b1);
      end else begin
         f = big ? {1'b0, {(OUT_W-1){1'b1}}} : m[OUT_W-1:0];
      end
      return f;
   endfunction

   logic [NUM_REGS-1:0][CFG_W-1:0] coeff_ff;
   logic [1:0]                     csr_idx;
   logic                           en;

   assign csr_idx    = csr_paddr[ADDR_W-1:3];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_idx)
            REG_AA: coeff_ff[0] <= csr_pwdata;
            REG_AB: coeff_ff[1] <= csr_pwdata;
            REG_BB: coeff_ff[2] <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_AA: csr_prdata = coeff_ff[0];
         REG_AB: csr_prdata = coeff_ff[1];
         REG_BB: csr_prdata = coeff_ff[2];
         default: csr_prdata = '0;
      endcase
   end

   // front
   logic      fr_valid;
   front_type fr_data;

   svdw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid && req_ready),
      .in_data   (req_data),
      .coeff     (coeff_ff),
      .out_valid (fr_valid),
      .out_data  (fr_data)
   );

   // root
   sq_side_type       sq_in_side;
   sq_side_type       sq_side;
   logic              sq_valid;
   logic [ROOT_W-1:0] root;

   assign sq_in_side.inr    = fr_data.inr;
   assign sq_in_side.dpos   = fr_data.dpos;
   assign sq_in_side.ad     = fr_data.ad;
   assign sq_in_side.radsum = fr_data.radsum;
   assign sq_in_side.ri     = fr_data.ri;
   assign sq_in_side.rj     = fr_data.rj;
   assign sq_in_side.ham    = fr_data.ham;
   assign sq_in_side.gmin   = fr_data.gmin;

   svdw_isqrt #(.NW(RSQ_W), .SW($bits(sq_side_type))) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_valid),
      .in_value  (fr_data.rsq),
      .in_side   (sq_in_side),
      .out_valid (sq_valid),
      .out_root  (root),
      .out_side  (sq_side)
   );

   // gap
   md_side_type       hs_ff;
   md_side_type       hs_in;
   logic [RAD_W-1:0]  hri_ff;
   logic [RAD_W-1:0]  hrj_ff;
   logic [RSUM_W-1:0] hrs_ff;
   logic              hs_vld_ff;

   always_comb begin
      logic [ROOT_W-1:0] rs;
      logic [ROOT_W-1:0] gap;
      logic [ROOT_W-1:0] hm;
      rs  = ROOT_W'(sq_side.radsum);
      gap = (root > rs) ? (root - rs) : '0;
      hm  = (gap < ROOT_W'(sq_side.gmin)) ? ROOT_W'(sq_side.gmin) : gap;
      hs_in.inr  = sq_side.inr;
      hs_in.dpos = sq_side.dpos;
      hs_in.ad   = sq_side.inr ? sq_side.ad : '0;
      hs_in.ham  = sq_side.ham;
      hs_in.h    = (hm == '0) ? ROOT_W'(1) : hm;
      hs_in.r    = sq_side.inr ? root : ROOT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hs_ff  <= hs_in;
         hri_ff <= sq_side.ri;
         hrj_ff <= sq_side.rj;
         hrs_ff <= (sq_side.radsum == '0) ? RSUM_W'(1) : sq_side.radsum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hs_vld_ff <= 1'b0;
      end else if (en) begin
         hs_vld_ff <= sq_valid;
      end
   end

   // reduced radius
   md_side_type      md_side;
   logic             md_valid;
   logic [RAD_W-1:0] reduced;

   svdw_muldiv #(.BW(RAD_W), .CW(RSUM_W), .SW($bits(md_side_type))) u_reduced (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (hs_vld_ff),
      .in_a      (RSUM_W'(hri_ff)),
      .in_b      (hrj_ff),
      .in_c      (hrs_ff),
      .in_side   (hs_ff),
      .out_valid (md_valid),
      .out_quot  (reduced),
      .out_side  (md_side)
   );

   // energy numerator and denominator
   ed_side_type        ps_ff;
   logic [2*HAM_W-1:0] prod_ff;
   logic [DEN_W-1:0]   h6_ff;
   logic               ps_vld_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ps_ff.inr  <= md_side.inr;
         ps_ff.dpos <= md_side.dpos;
         ps_ff.ad   <= md_side.ad;
         ps_ff.h    <= md_side.h;
         ps_ff.r    <= md_side.r;
         prod_ff    <= md_side.ham * reduced;
         h6_ff      <= DEN_W'({md_side.h, 2'b00}) + DEN_W'({md_side.h, 1'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ps_vld_ff <= 1'b0;
      end else if (en) begin
         ps_vld_ff <= md_valid;
      end
   end

   ed_side_type        ed_side;
   logic               ed_valid;
   logic [2*HAM_W-1:0] e_quot;

   svdw_div #(.NW(2*HAM_W), .DW(DEN_W), .SW($bits(ed_side_type))) u_energy (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (ps_vld_ff),
      .in_num    (prod_ff),
      .in_den    (h6_ff),
      .in_side   (ps_ff),
      .out_valid (ed_valid),
      .out_quot  (e_quot),
      .out_side  (ed_side)
   );

   // force magnitude
   fd_side_type       fd_in_side;
   fd_side_type       fd_side;
   logic              fd_valid;
   logic [FMAG_W-1:0] fmag;

   assign fd_in_side.inr  = ed_side.inr;
   assign fd_in_side.dpos = ed_side.dpos;
   assign fd_in_side.ad   = ed_side.ad;
   assign fd_in_side.r    = ed_side.r;
   assign fd_in_side.e    = e_quot[E_W-1:0];

   svdw_div #(.NW(FMAG_W), .DW(ROOT_W), .SW($bits(fd_side_type))) u_fmag (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (ed_valid),
      .in_num    ({e_quot[E_W-1:0], {FRAC_W{1'b0}}}),
      .in_den    (ed_side.h),
      .in_side   (fd_in_side),
      .out_valid (fd_valid),
      .out_quot  (fmag),
      .out_side  (fd_side)
   );

   // per-axis scaling
   lane_side_type     l0_in_side;
   lane_side_type     l0_side;
   logic [1:0]        l_side;
   logic [2:0]        l_valid;
   logic [FMAG_W-1:0] m_x;
   logic [FMAG_W-1:0] m_y;
   logic [FMAG_W-1:0] m_z;

   assign l0_in_side.inr  = fd_side.inr;
   assign l0_in_side.e    = fd_side.e;
   assign l0_in_side.dpos = fd_side.dpos[2];

   svdw_muldiv #(.BW(FMAG_W), .CW(ROOT_W), .SW($bits(lane_side_type))) u_lane_x (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fd_valid),
      .in_a      (ROOT_W'(fd_side.ad[2])),
      .in_b      (fmag),
      .in_c      (fd_side.r),
      .in_side   (l0_in_side),
      .out_valid (l_valid[0]),
      .out_quot  (m_x),
      .out_side  (l0_side)
   );

   svdw_muldiv #(.BW(FMAG_W), .CW(ROOT_W), .SW(1)) u_lane_y (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fd_valid),
      .in_a      (ROOT_W'(fd_side.ad[1])),
      .in_b      (fmag),
      .in_c      (fd_side.r),
      .in_side   (fd_side.dpos[1]),
      .out_valid (l_valid[1]),
      .out_quot  (m_y),
      .out_side  (l_side[0])
   );

   svdw_muldiv #(.BW(FMAG_W), .CW(ROOT_W), .SW(1)) u_lane_z (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fd_valid),
      .in_a      (ROOT_W'(fd_side.ad[0])),
      .in_b      (fmag),
      .in_c      (fd_side.r),
      .in_side   (fd_side.dpos[0]),
      .out_valid (l_valid[2]),
      .out_quot  (m_z),
      .out_side  (l_side[1])
   );

   // saturate and zero out of range
   rsp_type o_ff;
   logic    o_vld_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         o_ff.force_x     <= sat_force(l0_side.dpos, m_x);
         o_ff.force_y     <= sat_force(l_side[0], m_y);
         o_ff.force_z     <= sat_force(l_side[1], m_z);
         o_ff.pair_energy <= l0_side.inr ? (~OUT_W'(l0_side.e) + 1'b1) : '0;
         o_ff.in_range    <= l0_side.inr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else if (en) begin
         o_vld_ff <= l_valid[0] && l_valid[1] && l_valid[2];
      end
   end

   // result buffer
   rsp_type    q_ff [2];
   logic       wp_ff;
   logic       rp_ff;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       push;
   logic       pop;

   assign en        = (cnt_ff != 2'd2);
   assign req_ready = en;
   assign push      = en && o_vld_ff;
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = q_ff[rp_ff];

   always_comb begin
      unique case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= o_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wp_ff <= ~wp_ff;
         end
         if (pop) begin
            rp_ff <= ~rp_ff;
         end
         cnt_ff <= cnt_in;
      end
   end

`ifndef SYNTH
   a_buf_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result buffer overfilled");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) && !pop |=> (cnt_ff == 2'd2))
      else $error("result buffer lost a beat while full");

   a_out_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.in_range |-> (rsp_data.pair_energy == '0)
         && (rsp_data.force_x == '0) && (rsp_data.force_y == '0)
         && (rsp_data.force_z == '0))
      else $error("out-of-range beat carries non-zero values");

   a_energy_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.pair_energy[OUT_W-1] || (rsp_data.pair_energy == '0))
      else $error("positive pair energy");
`endif

endmodule

FILE: verif/sphere_vdw_pair_force_checker.sv
// Checker for the sphere pair force block: predicts each rsp beat and compares it.
module sphere_vdw_pair_force_checker import svdw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  req_type           req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  rsp_type           rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [CFG_W-1:0]  csr_pwdata,
   input  logic              csr_pready,
   output int                pending,
   output int                errors
);

   localparam longint unsigned FAR_LIM = 64'h800_0000;
   localparam longint unsigned NEG_MAG = 64'h8000_0000_0000;
   localparam longint unsigned POS_MAG = 64'h7FFF_FFFF_FFFF;

   logic [CFG_W-1:0] coeff_aa, coeff_ab, coeff_bb;
   rsp_type          force_q[$];

   function automatic longint unsigned int_root(longint unsigned v);
      longint unsigned res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v = v - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   function automatic logic [OUT_W-1:0] axis_force(longint signed d, longint unsigned fmag,
                                                   longint unsigned r);
      longint unsigned ad, m;
      longint signed f;
      ad = (d < 0) ? longint'(-d) : longint'(d);
      m = ad * (fmag / r) + (ad * (fmag % r)) / r;
      if (d > 0)
         f = (m >= NEG_MAG) ? -longint'(NEG_MAG) : -longint'(m);
      else
         f = (m > POS_MAG) ? longint'(POS_MAG) : longint'(m);
      return f[OUT_W-1:0];
   endfunction

   function automatic rsp_type pair_force(req_type p);
      longint signed   d[3];
      longint unsigned ad, rsq, ri, rj, radsum, coeff, ham, gmin, cut;
      longint unsigned lo, hi, r, h, red, e, fmag;
      bit              far;
      rsp_type         o;
      o = '0;
      far = 0;
      rsq = 0;
      d[0] = longint'(p.pos_i_x) - longint'(p.pos_j_x);
      d[1] = longint'(p.pos_i_y) - longint'(p.pos_j_y);
      d[2] = longint'(p.pos_i_z) - longint'(p.pos_j_z);
      for (int k = 0; k < 3; k++) begin
         ad = (d[k] < 0) ? longint'(-d[k]) : longint'(d[k]);
         if (ad >= FAR_LIM) far = 1;
         else rsq = rsq + ad * ad;
      end
      ri = 64'(p.radius_i);
      rj = 64'(p.radius_j);
      radsum = ri + rj;
      if (!p.type_i && !p.type_j) coeff = coeff_aa;
      else if (p.type_i && p.type_j) coeff = coeff_bb;
      else coeff = coeff_ab;
      ham = 64'(coeff[23:0]);
      gmin = 64'(coeff[43:24]);
      cut = 64'(coeff[63:44]);
      if (far) return o;
      lo = radsum * radsum;
      hi = (radsum + cut) * (radsum + cut);
      if (!(rsq > lo && rsq <= hi)) return o;
      r = int_root(rsq);
      h = (r > radsum) ? r - radsum : 0;
      if (h < gmin) h = gmin;
      if (h == 0) h = 1;
      red = (radsum == 0) ? 0 : (ri * rj) / radsum;
      e = (ham * red) / (6 * h);
      fmag = (e << FRAC_W) / h;
      o.force_x = axis_force(d[0], fmag, r);
      o.force_y = axis_force(d[1], fmag, r);
      o.force_z = axis_force(d[2], fmag, r);
      o.pair_energy = OUT_W'(-longint'(e));
      o.in_range = 1'b1;
      return o;
   endfunction

   task automatic report(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
   endtask

   initial errors = 0;
   assign pending = force_q.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         coeff_aa <= '0;
         coeff_ab <= '0;
         coeff_bb <= '0;
         force_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:3])
               REG_AA: coeff_aa <= csr_pwdata;
               REG_AB: coeff_ab <= csr_pwdata;
               REG_BB: coeff_bb <= csr_pwdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) force_q.push_back(pair_force(req_data));
         if (rsp_valid && rsp_ready) begin
            if (force_q.size() == 0) begin
               report("unexpected rsp beat", rsp_data.force_x, '0);
            end else begin
               want = force_q.pop_front();
               if (rsp_data.force_x !== want.force_x)
                  report("force_x", rsp_data.force_x, want.force_x);
               if (rsp_data.force_y !== want.force_y)
                  report("force_y", rsp_data.force_y, want.force_y);
               if (rsp_data.force_z !== want.force_z)
                  report("force_z", rsp_data.force_z, want.force_z);
               if (rsp_data.pair_energy !== want.pair_energy)
                  report("pair_energy", rsp_data.pair_energy, want.pair_energy);
               if (rsp_data.in_range !== want.in_range)
                  report("in_range", OUT_W'(rsp_data.in_range), OUT_W'(want.in_range));
            end
         end
      end
   end

   final if (force_q.size() != 0) $display("%0d rsp beats never arrived", force_q.size());

endmodule

FILE: verif/sphere_vdw_pair_force_tb.sv
// Testbench top for the sphere pair force block: stimulus, idling and verdict.
module sphere_vdw_pair_force_tb import svdw_pkg::*;;

   localparam int WATCH_LIMIT = 20000;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   rsp_type           rsp_data;
   logic              csr_psel = 0;
   logic              csr_penable = 0;
   logic              csr_pwrite = 0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [CFG_W-1:0]  csr_pwdata = '0;
   logic [CFG_W-1:0]  csr_prdata;
   logic              csr_pready;
   int                pending, errors;
   bit                calm = 0;
   int                quiet = 0;
   int                stall = 0;
   logic [CFG_W-1:0]  coeff[3];

   always #1 clock = ~clock;

   sphere_vdw_pair_force dut (.*);

   sphere_vdw_pair_force_checker chk (.*);

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else if (stall > 0) begin
         stall <= stall - 1;
         rsp_ready <= 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall <= int'($urandom_range(0, 4));
         rsp_ready <= 0;
      end else begin
         rsp_ready <= 1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > WATCH_LIMIT) begin
         $display("sphere_vdw_pair_force_tb NOT OK");
         $finish;
      end
   end

   task automatic csr_write(logic [ADDR_W-1:0] addr, logic [CFG_W-1:0] val);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= addr;
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   task automatic set_coeffs(logic [CFG_W-1:0] aa, logic [CFG_W-1:0] ab, logic [CFG_W-1:0] bb);
      coeff[0] = aa;
      coeff[1] = ab;
      coeff[2] = bb;
      csr_write(5'd0, aa);
      csr_write(5'd8, ab);
      csr_write(5'd16, bb);
   endtask

   task automatic send(req_type p);
      req_valid <= 1;
      req_data <= p;
      forever begin
         @(negedge clock);
         if (req_ready) break;
      end
      @(posedge clock);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   function automatic req_type place(longint signed dx, longint signed dy, longint signed dz,
                                     longint unsigned ri, longint unsigned rj, bit ti, bit tj);
      req_type p;
      longint signed jx, jy, jz;
      jx = longint'($urandom_range(0, 32'h8000_0000)) - 64'sh4000_0000;
      jy = longint'($urandom_range(0, 32'h8000_0000)) - 64'sh4000_0000;
      jz = longint'($urandom_range(0, 32'h8000_0000)) - 64'sh4000_0000;
      p.pos_j_x = POS_W'(jx);
      p.pos_j_y = POS_W'(jy);
      p.pos_j_z = POS_W'(jz);
      p.pos_i_x = POS_W'(jx + dx);
      p.pos_i_y = POS_W'(jy + dy);
      p.pos_i_z = POS_W'(jz + dz);
      p.radius_i = RAD_W'(ri);
      p.radius_j = RAD_W'(rj);
      p.type_i = ti;
      p.type_j = tj;
      return p;
   endfunction

   function automatic req_type random_pair();
      req_type p;
      int unsigned ri, rj, cut;
      longint signed t, ax, ay, az;
      bit ti, tj;
      logic [CFG_W-1:0] c;
      if ($urandom_range(0, 4) == 0) begin
         p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              24'($urandom), 24'($urandom), 1'($urandom), 1'($urandom)};
         return p;
      end
      ti = 1'($urandom);
      tj = 1'($urandom);
      c = (!ti && !tj) ? coeff[0] : (ti && tj) ? coeff[2] : coeff[1];
      cut = 32'(c[63:44]);
      if ($urandom_range(0, 9) == 0) begin
         ri = $urandom_range(1, 24'hFF_FFFF);
         rj = $urandom_range(1, 24'hFF_FFFF);
      end else begin
         ri = $urandom_range(1, 32'h4_0000);
         rj = $urandom_range(1, 32'h4_0000);
      end
      t = longint'(ri + rj + (($urandom_range(0, 7) == 0) ? cut : $urandom_range(0, cut)));
      if ($urandom_range(0, 1)) begin
         ax = t;
         ay = longint'($urandom_range(0, 3));
         az = 0;
      end else begin
         ax = longint'($urandom_range(0, 32'(t)));
         ay = longint'($urandom_range(0, 32'(t - ax)));
         az = t - ax - ay;
      end
      if ($urandom_range(0, 1)) ax = -ax;
      if ($urandom_range(0, 1)) ay = -ay;
      if ($urandom_range(0, 1)) az = -az;
      case ($urandom_range(0, 2))
         0: p = place(ax, ay, az, ri, rj, ti, tj);
         1: p = place(ay, az, ax, ri, rj, ti, tj);
         default: p = place(az, ax, ay, ri, rj, ti, tj);
      endcase
      return p;
   endfunction

   function automatic logic [CFG_W-1:0] random_coeff(int unsigned cut_max);
      return {20'($urandom_range(0, cut_max)), 20'($urandom_range(0, 32'h400)), 24'($urandom)};
   endfunction

   initial begin
      req_type p;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      set_coeffs({20'h4_0000, 20'h0, 24'hFF_FFFF}, {20'hF_FFFF, 20'h100, 24'h1_0000},
                 {20'h0_1000, 20'hF_FFFF, 24'hAB_CDEF});
      csr_write(5'd24, '1);
      send(place(10, 1, 0, 5, 5, 0, 0));
      send(place(-10, 0, 1, 5, 5, 0, 0));
      send(place(0, 0, 0, 0, 0, 0, 0));
      send(place(1, 0, 0, 0, 0, 0, 0));
      send(place(27'sh400_0000 + 27'sh3ff_ffff, 0, 0, 1, 1, 0, 1));
      send(place(64'sh800_0000, 0, 0, 1, 1, 0, 0));
      send(place(0, -64'sh800_0000, 0, 1, 1, 1, 1));
      send(place(0, 0, 64'sh7ff_ffff, 24'hFF_FFFF, 24'hFF_FFFF, 1, 0));
      send(place(0, 0, 64'sh200_0000 + 64'sh10_0000, 24'hFF_FFFF, 24'hFF_FFFF, 0, 1));
      send(place(-64'sh50_0000, 0, 0, 24'hFF_FFFF, 24'hFF_FFFF, 0, 0));
      send(place(64'sh3_0000, 64'sh3_0000, 64'sh3_0000, 64'h1_0000, 64'h1_0000, 0, 1));
      send(place(-64'sh3_0000, -64'sh3_0000, -64'sh3_0000, 64'h1_0000, 1, 1, 0));
      send(place(64'sh2_1000, 0, 0, 64'h1_0000, 64'h1_0000, 1, 1));
      send(place(64'sh2_0001, 0, 0, 64'h1_0000, 64'h1_0000, 1, 1));
      send(place(64'sh10_0000, 0, 0, 64'h1_0000, 64'h1_0000, 0, 0));
      p = '0;
      p.pos_i_x = 32'sh7FFF_FFFF;
      p.pos_j_x = 32'sh8000_0000;
      p.pos_i_y = 32'sh8000_0000;
      p.pos_j_y = 32'sh7FFF_FFFF;
      p.radius_i = '1;
      p.radius_j = '1;
      p.type_i = 1;
      p.type_j = 1;
      send(p);
      p = '1;
      send(p);
      repeat (300) send(random_pair());
      drain();

      set_coeffs('1, '1, '1);
      repeat (350) send(random_pair());
      drain();

      set_coeffs('0, {20'h1_0000, 20'h0, 24'h1}, {20'h8_0000, 20'h0, 24'hFF_FFFF});
      repeat (350) send(random_pair());
      drain();

      set_coeffs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      repeat (350) send(random_pair());
      drain();

      set_coeffs(random_coeff(20'hF_FFFF), random_coeff(20'h4_0000), random_coeff(20'h2_0000));
      repeat (350) send(random_pair());
      drain();

      calm = 1;
      set_coeffs(random_coeff(20'h8_0000), random_coeff(20'hF_FFFF), random_coeff(20'h1_0000));
      repeat (300) send(random_pair());
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (250) @(posedge clock);

      if (errors == 0)
         $display("sphere_vdw_pair_force_tb OK");
      else
         $display("sphere_vdw_pair_force_tb NOT OK");
      $finish;
   end

endmodule
